FILE: rtl/ffb_pkg.sv
// ----------------------------------------------------------------------------
// ffb_pkg
// Shared types for the first-fit block allocator: result codes, datapath
// command and status groups, elaboration helpers.
// ----------------------------------------------------------------------------
package ffb_pkg;

    typedef enum logic [2:0] {
        ST_GRANTED  = 3'd0,
        ST_BAD_SIZE = 3'd1,
        ST_NO_SPACE = 3'd2,
        ST_FREED    = 3'd3,
        ST_IGNORED  = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_PAGE_INIT,
        DP_NEXT_PAGE,
        DP_READ_CUR,
        DP_ALLOC_EVAL,
        DP_WRITE_SPLIT,
        DP_WRITE_PREV,
        DP_WRITE_CUR,
        DP_FREE_CHECK,
        DP_READ_C,
        DP_FREE_SIZE,
        DP_FREE_STEP,
        DP_FREE_CHDR,
        DP_WRITE_C,
        DP_FREE_LINK
    } t_dp_op;

    typedef struct packed {
        t_dp_op  op;
    } t_dp_cmd;

    typedef struct packed {
        logic is_free;
        logic bad_size;
        logic last_page;
        logic fit;
        logic split;
        logic valid;
        logic bad;
        logic walk_more;
        logic ignore;
        logic merge;
    } t_dp_stat;

    // count of trailing zero bits, used at elaboration only
    function automatic int ctz(input int v);
        int n;
        n = 0;
        for (int i = 0; i < 31; i++) begin
            if ((((v >> i) & 1) == 0) && (n == i)) begin
                n = i + 1;
            end
        end
        return n;
    endfunction

endpackage

FILE: rtl/ffb_ram.sv
// ----------------------------------------------------------------------------
// ffb_ram
// Generic simple dual-port RAM: one write and one read per cycle, registered read.
// ----------------------------------------------------------------------------
module ffb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/ffb_dpath.sv
// ----------------------------------------------------------------------------
// ffb_dpath
// Allocator datapath: header memory, per-page list heads and start bits,
// walk registers, size and bound arithmetic.
// ----------------------------------------------------------------------------
module ffb_dpath #(
    parameter int PAGE_BYTES    = 4096,
    parameter int PAGE_COUNT    = 4,
    parameter int GRANULE_BYTES = 8,
    parameter int HEADER_BYTES  = 8,
    parameter int OFF_W         = 12,
    parameter int PG_W          = 2,
    parameter int REQ_W         = 13,
    parameter int ADDR_W        = 14
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ffb_pkg::t_dp_cmd      i_cmd,
    input  logic                  i_ld_op,
    input  logic [REQ_W-1:0]      i_ld_req,
    input  logic [ADDR_W-1:0]     i_ld_rel,
    output ffb_pkg::t_dp_stat     o_stat,
    output logic [ADDR_W-1:0]     o_grant_addr
);
    import ffb_pkg::*;

    localparam int ALIGN  = (ctz(GRANULE_BYTES) < ctz(HEADER_BYTES)) ?
                            ctz(GRANULE_BYTES) : ctz(HEADER_BYTES);
    localparam int RAM_AW = PG_W + OFF_W - ALIGN;
    localparam int HW     = 2 * OFF_W + 1;
    localparam int XW     = OFF_W + 2;
    localparam logic [XW-1:0]    HDR_X  = XW'(HEADER_BYTES);
    localparam logic [XW-1:0]    PAGE_X = XW'(PAGE_BYTES);
    localparam logic [OFF_W-1:0] HDR_O  = OFF_W'(HEADER_BYTES);

    typedef struct packed {
        logic [OFF_W-1:0] size;
        logic [OFF_W-1:0] next;
        logic             link;
    } t_hdr;

    function automatic logic [RAM_AW-1:0] idx(input logic [PG_W-1:0] p,
                                              input logic [OFF_W-1:0] o);
        return {p, o[OFF_W-1:ALIGN]};
    endfunction

    // request latch
    logic              r_op;
    logic [REQ_W-1:0]  r_req;
    logic [ADDR_W-1:0] r_rel;
    // page state
    logic [PAGE_COUNT-1:0] r_started;
    logic [OFF_W-1:0]      r_head_off [PAGE_COUNT];
    logic [PAGE_COUNT-1:0] r_head_vld;
    // walk
    logic [PG_W-1:0]  r_page;
    logic [OFF_W-1:0] r_cur, r_prev, r_psize;
    logic             r_valid, r_has_prev;
    logic [OFF_W-1:0] r_hsize, r_hnext, r_rem;
    logic             r_hlink, r_fit, r_split;
    // block being freed
    logic [OFF_W-1:0] r_c, r_csize, r_cnext;
    logic             r_clink, r_bad;

    // memory port
    logic              ram_we;
    logic [RAM_AW-1:0] ram_waddr, ram_raddr;
    t_hdr              ram_wdata, rd;
    logic [HW-1:0]     ram_rdata;

    ffb_ram #(.WIDTH(HW), .DEPTH(2 ** RAM_AW)) u_hdr_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd = t_hdr'(ram_rdata);

    // arithmetic
    logic [XW-1:0]         rem_x, c_end, p_end;
    logic                  split_now;
    logic [OFF_W-1:0]      noff, link_tgt;
    logic                  link_vld;
    logic [PG_W-1:0]       rel_page;
    logic [OFF_W-1:0]      rel_off;
    logic                  rel_in_range, cur_started;
    logic                  cur_head_vld;
    logic [OFF_W-1:0]      cur_head_off;

    assign rem_x     = XW'(rd.size) - XW'(r_req) - HDR_X;
    assign split_now = !rem_x[XW-1] && (rem_x >= HDR_X);
    assign noff      = OFF_W'(XW'(r_cur) + HDR_X + XW'(r_req));
    assign link_tgt  = r_split ? noff : r_hnext;
    assign link_vld  = r_split ? 1'b1 : r_hlink;
    assign c_end     = XW'(r_c) + HDR_X + XW'(r_csize);
    assign p_end     = XW'(r_prev) + HDR_X + XW'(r_psize);

    assign rel_page     = r_rel[ADDR_W-1 -: PG_W];
    assign rel_off      = r_rel[OFF_W-1:0];
    assign rel_in_range = 32'(rel_page) < PAGE_COUNT;
    assign cur_started  = rel_in_range && r_started[rel_page];
    assign cur_head_vld = rel_in_range && r_head_vld[rel_page];
    assign cur_head_off = rel_in_range ? r_head_off[rel_page] : '0;

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = idx(r_page, r_cur);
        ram_wdata = '0;
        ram_raddr = idx(r_page, r_cur);
        unique case (i_cmd.op)
            DP_PAGE_INIT: begin
                ram_we    = !r_started[r_page];
                ram_waddr = idx(r_page, '0);
                ram_wdata = '{size: OFF_W'(PAGE_BYTES - HEADER_BYTES), next: '0, link: 1'b0};
            end
            DP_WRITE_SPLIT: begin
                ram_we    = 1'b1;
                ram_waddr = idx(r_page, noff);
                ram_wdata = '{size: r_rem, next: r_hnext, link: r_hlink};
            end
            DP_WRITE_PREV: begin
                ram_we    = r_has_prev;
                ram_waddr = idx(r_page, r_prev);
                ram_wdata = '{size: r_psize, next: link_tgt, link: link_vld};
            end
            DP_WRITE_CUR: begin
                ram_we    = 1'b1;
                ram_wdata = '{size: r_split ? OFF_W'(r_req) : r_hsize,
                              next: r_hnext, link: 1'b0};
            end
            DP_READ_C: begin
                ram_raddr = idx(r_page, r_c);
            end
            DP_WRITE_C: begin
                ram_we    = 1'b1;
                ram_waddr = idx(r_page, r_c);
                ram_wdata = '{size: r_csize, next: r_cnext, link: r_clink};
            end
            DP_FREE_LINK: begin
                ram_we    = r_has_prev;
                ram_waddr = idx(r_page, r_prev);
                if (p_end == XW'(r_c)) begin
                    ram_wdata = '{size: OFF_W'(p_end - XW'(r_prev) + XW'(r_csize)),
                                  next: r_cnext, link: r_clink};
                end else begin
                    ram_wdata = '{size: r_psize, next: r_c, link: 1'b1};
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started  <= '0;
            r_head_vld <= '0;
        end else begin
            unique case (i_cmd.op)
                DP_PAGE_INIT: begin
                    if (!r_started[r_page]) begin
                        r_started[r_page]  <= 1'b1;
                        r_head_vld[r_page] <= 1'b1;
                    end
                end
                DP_WRITE_PREV: begin
                    if (!r_has_prev) begin
                        r_head_vld[r_page] <= link_vld;
                    end
                end
                DP_FREE_LINK: begin
                    if (!r_has_prev) begin
                        r_head_vld[r_page] <= 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            DP_LOAD: begin
                r_op   <= i_ld_op;
                r_req  <= i_ld_req;
                r_rel  <= i_ld_rel;
                r_page <= '0;
                r_fit  <= 1'b0;
                r_bad  <= 1'b0;
            end
            DP_PAGE_INIT: begin
                if (!r_started[r_page]) begin
                    r_head_off[r_page] <= '0;
                end
                r_cur      <= r_started[r_page] ? r_head_off[r_page] : '0;
                r_valid    <= r_started[r_page] ? r_head_vld[r_page] : 1'b1;
                r_has_prev <= 1'b0;
                r_fit      <= 1'b0;
            end
            DP_NEXT_PAGE: begin
                r_page <= r_page + 1'b1;
            end
            DP_ALLOC_EVAL: begin
                r_hsize <= rd.size;
                r_hnext <= rd.next;
                r_hlink <= rd.link;
                r_rem   <= OFF_W'(rem_x);
                r_split <= split_now;
                r_fit   <= XW'(rd.size) >= XW'(r_req);
                if (XW'(rd.size) < XW'(r_req)) begin
                    r_has_prev <= 1'b1;
                    r_prev     <= r_cur;
                    r_psize    <= rd.size;
                    r_valid    <= rd.link;
                    r_cur      <= rd.next;
                end
            end
            DP_WRITE_PREV: begin
                if (!r_has_prev) begin
                    r_head_off[r_page] <= link_tgt;
                end
            end
            DP_FREE_CHECK: begin
                r_page     <= rel_page;
                r_bad      <= !cur_started || (rel_off < HDR_O);
                r_c        <= rel_off - HDR_O;
                r_cur      <= cur_head_off;
                r_valid    <= cur_head_vld;
                r_has_prev <= 1'b0;
            end
            DP_FREE_SIZE: begin
                r_csize <= rd.size;
                r_bad   <= (XW'(r_c) + HDR_X + XW'(rd.size)) > PAGE_X;
            end
            DP_FREE_STEP: begin
                r_has_prev <= 1'b1;
                r_prev     <= r_cur;
                r_psize    <= rd.size;
                r_valid    <= rd.link;
                r_cur      <= rd.next;
            end
            DP_FREE_CHDR: begin
                if (o_stat.merge) begin
                    r_csize <= OFF_W'(XW'(r_csize) + HDR_X + XW'(rd.size));
                    r_cnext <= rd.next;
                    r_clink <= rd.link;
                end else begin
                    r_cnext <= r_cur;
                    r_clink <= r_valid;
                end
            end
            DP_FREE_LINK: begin
                if (!r_has_prev) begin
                    r_head_off[r_page] <= r_c;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_stat.is_free   = r_op;
        o_stat.bad_size  = ((32'(r_req) & (GRANULE_BYTES - 1)) != 0) ||
                           (32'(r_req) > PAGE_BYTES - HEADER_BYTES);
        o_stat.last_page = 32'(r_page) == PAGE_COUNT - 1;
        o_stat.fit       = r_fit;
        o_stat.split     = r_split;
        o_stat.valid     = r_valid;
        o_stat.bad       = r_bad;
        o_stat.walk_more = r_valid && (r_cur < r_c);
        o_stat.ignore    = (r_valid && (r_cur <= r_c)) ||
                           (r_valid && (c_end > XW'(r_cur))) ||
                           (r_has_prev && (p_end > XW'(r_c)));
        o_stat.merge     = r_valid && (c_end == XW'(r_cur));
    end

    assign o_grant_addr = {r_page, r_cur + HDR_O};
endmodule

FILE: rtl/ffb_ctrl.sv
// ----------------------------------------------------------------------------
// ffb_ctrl
// Allocator sequencer: one request at a time, drives datapath commands and
// hands the result code to the output stage.
// ----------------------------------------------------------------------------
module ffb_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic                i_out_free,
    input  ffb_pkg::t_dp_stat   i_stat,
    output logic                o_ready,
    output logic                o_push,
    output ffb_pkg::t_status    o_code,
    output ffb_pkg::t_dp_cmd    o_cmd
);
    import ffb_pkg::*;

    typedef enum logic [20:0] {
        S_IDLE     = 21'd1 << 0,
        S_DISPATCH = 21'd1 << 1,
        S_A_PAGE   = 21'd1 << 2,
        S_A_TEST   = 21'd1 << 3,
        S_A_READ   = 21'd1 << 4,
        S_A_EVAL   = 21'd1 << 5,
        S_A_SPLIT  = 21'd1 << 6,
        S_A_PREV   = 21'd1 << 7,
        S_A_CUR    = 21'd1 << 8,
        S_F_CHECK  = 21'd1 << 9,
        S_F_GATE   = 21'd1 << 10,
        S_F_READC  = 21'd1 << 11,
        S_F_SIZE   = 21'd1 << 12,
        S_F_LOOP   = 21'd1 << 13,
        S_F_READ   = 21'd1 << 14,
        S_F_STEP   = 21'd1 << 15,
        S_F_READN  = 21'd1 << 16,
        S_F_CHDR   = 21'd1 << 17,
        S_F_WRC    = 21'd1 << 18,
        S_F_LINK   = 21'd1 << 19,
        S_RESULT   = 21'd1 << 20
    } t_state;

    t_state  r_state, n_state;
    t_status r_code, n_code;

    always_comb begin
        n_state  = r_state;
        n_code   = r_code;
        o_cmd.op = DP_NOP;
        o_push   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_accept) begin
                    o_cmd.op = DP_LOAD;
                    n_state  = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (i_stat.is_free) begin
                    n_state = S_F_CHECK;
                end else if (i_stat.bad_size) begin
                    n_code  = ST_BAD_SIZE;
                    n_state = S_RESULT;
                end else begin
                    n_state = S_A_PAGE;
                end
            end
            S_A_PAGE: begin
                o_cmd.op = DP_PAGE_INIT;
                n_state  = S_A_TEST;
            end
            S_A_TEST: begin
                if (i_stat.fit) begin
                    n_state = i_stat.split ? S_A_SPLIT : S_A_PREV;
                end else if (i_stat.valid) begin
                    n_state = S_A_READ;
                end else if (i_stat.last_page) begin
                    n_code  = ST_NO_SPACE;
                    n_state = S_RESULT;
                end else begin
                    o_cmd.op = DP_NEXT_PAGE;
                    n_state  = S_A_PAGE;
                end
            end
            S_A_READ: begin
                o_cmd.op = DP_READ_CUR;
                n_state  = S_A_EVAL;
            end
            S_A_EVAL: begin
                o_cmd.op = DP_ALLOC_EVAL;
                n_state  = S_A_TEST;
            end
            S_A_SPLIT: begin
                o_cmd.op = DP_WRITE_SPLIT;
                n_state  = S_A_PREV;
            end
            S_A_PREV: begin
                o_cmd.op = DP_WRITE_PREV;
                n_state  = S_A_CUR;
            end
            S_A_CUR: begin
                o_cmd.op = DP_WRITE_CUR;
                n_code   = ST_GRANTED;
                n_state  = S_RESULT;
            end
            S_F_CHECK: begin
                o_cmd.op = DP_FREE_CHECK;
                n_state  = S_F_GATE;
            end
            S_F_GATE: begin
                if (i_stat.bad) begin
                    n_code  = ST_IGNORED;
                    n_state = S_RESULT;
                end else begin
                    n_state = S_F_READC;
                end
            end
            S_F_READC: begin
                o_cmd.op = DP_READ_C;
                n_state  = S_F_SIZE;
            end
            S_F_SIZE: begin
                o_cmd.op = DP_FREE_SIZE;
                n_state  = S_F_LOOP;
            end
            S_F_LOOP: begin
                if (i_stat.bad) begin
                    n_code  = ST_IGNORED;
                    n_state = S_RESULT;
                end else if (i_stat.walk_more) begin
                    n_state = S_F_READ;
                end else if (i_stat.ignore) begin
                    n_code  = ST_IGNORED;
                    n_state = S_RESULT;
                end else if (i_stat.merge) begin
                    n_state = S_F_READN;
                end else begin
                    n_state = S_F_CHDR;
                end
            end
            S_F_READ: begin
                o_cmd.op = DP_READ_CUR;
                n_state  = S_F_STEP;
            end
            S_F_STEP: begin
                o_cmd.op = DP_FREE_STEP;
                n_state  = S_F_LOOP;
            end
            S_F_READN: begin
                o_cmd.op = DP_READ_CUR;
                n_state  = S_F_CHDR;
            end
            S_F_CHDR: begin
                o_cmd.op = DP_FREE_CHDR;
                n_state  = S_F_WRC;
            end
            S_F_WRC: begin
                o_cmd.op = DP_WRITE_C;
                n_state  = S_F_LINK;
            end
            S_F_LINK: begin
                o_cmd.op = DP_FREE_LINK;
                n_code   = ST_FREED;
                n_state  = S_RESULT;
            end
            S_RESULT: begin
                if (i_out_free) begin
                    o_push  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_code  <= ST_GRANTED;
        end else begin
            r_state <= n_state;
            r_code  <= n_code;
        end
    end

    assign o_ready = r_state == S_IDLE;
    assign o_code  = r_code;
endmodule

FILE: rtl/first_fit_block_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit allocator over a paged arena with address-ordered free lists and
// coalescing on free.
// ----------------------------------------------------------------------------
//  channel | dir | handshake                  | payload
//  --------+-----+----------------------------+---------------------------------
//  request | in  | i_s_tvalid / o_s_tready    | i_s_tdata: op, bytes, address
//  result  | out | o_m_tvalid / i_m_tready    | o_m_tdata: granted addr, status
//
//  One request at a time. Each free list node visited takes a header RAM read,
//  an evaluate step and a test. An allocate visits pages in order and ends with
//  its header writes (one more on a split); a free checks the address, reads
//  the block size, walks to its place, reads the next block on a merge and
//  writes the block and link headers; a bad size goes straight to the result.
//  Reset (i_rst_n low, synchronous) empties all pages; header RAM needs none.
//  A finished result sits in the output register while the next request is
//  taken; the sequencer stalls only when a second result has nowhere to go.
//  PAGE_BYTES and GRANULE_BYTES must be powers of two; the block does not check.
// ----------------------------------------------------------------------------
module first_fit_block_allocator #(
    parameter int PAGE_BYTES    = 4096,
    parameter int PAGE_COUNT    = 4,
    parameter int GRANULE_BYTES = 8,
    parameter int HEADER_BYTES  = 8,
    localparam int OFF_W   = $clog2(PAGE_BYTES),
    localparam int PG_W    = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1,
    localparam int REQ_W   = $clog2(PAGE_BYTES + 1),
    localparam int ADDR_W  = OFF_W + PG_W,
    localparam int SDATA_W = ((1 + REQ_W + ADDR_W + 7) / 8) * 8,
    localparam int MDATA_W = ((ADDR_W + 3 + 7) / 8) * 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    // [0] operation, then request_bytes, then release_address, zero pad
    input  logic [SDATA_W-1:0] i_s_tdata,
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    // granted_address from bit 0, then status (3 bits), zero pad
    output logic [MDATA_W-1:0] o_m_tdata
);
    import ffb_pkg::*;

    t_dp_cmd           cmd;
    t_dp_stat          stat;
    t_status           code;
    logic              accept, push, out_free;
    logic [ADDR_W-1:0] grant_addr;
    logic              r_m_valid;
    logic [MDATA_W-1:0] r_m_data;

    assign accept   = i_s_tvalid && o_s_tready;
    assign out_free = !r_m_valid || i_m_tready;

    ffb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_out_free (out_free),
        .i_stat     (stat),
        .o_ready    (o_s_tready),
        .o_push     (push),
        .o_code     (code),
        .o_cmd      (cmd)
    );

    ffb_dpath #(
        .PAGE_BYTES    (PAGE_BYTES),
        .PAGE_COUNT    (PAGE_COUNT),
        .GRANULE_BYTES (GRANULE_BYTES),
        .HEADER_BYTES  (HEADER_BYTES),
        .OFF_W         (OFF_W),
        .PG_W          (PG_W),
        .REQ_W         (REQ_W),
        .ADDR_W        (ADDR_W)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_ld_op      (i_s_tdata[0]),
        .i_ld_req     (i_s_tdata[REQ_W:1]),
        .i_ld_rel     (i_s_tdata[REQ_W+ADDR_W:REQ_W+1]),
        .o_stat       (stat),
        .o_grant_addr (grant_addr)
    );

    // output register; address is zero for anything but a grant
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (push) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_m_data <= MDATA_W'({code, (code == ST_GRANTED) ? grant_addr : '0});
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
endmodule

FILE: tb/sv/tb_first_fit_block_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_first_fit_block_allocator
// Drives allocate and free requests into the allocator and checks each
// returned address and status. The expected results come from a behavioral
// model of the paged first-fit heap that is kept inside this testbench.
// ----------------------------------------------------------------------------
module tb_first_fit_block_allocator;
    import ffb_pkg::*;

    localparam int PG_BYTES   = 4096;
    localparam int PG_COUNT   = 4;
    localparam int GRAN       = 8;
    localparam int HDR        = 8;
    localparam int ARENA      = PG_BYTES * PG_COUNT;
    localparam int WALK_LIMIT = PG_BYTES / HDR + 1;
    localparam int N_RANDOM   = 1600;
    localparam int IDLE_LIMIT = 40000;
    localparam bit OP_ALLOC   = 1'b0;
    localparam bit OP_FREE    = 1'b1;

    typedef struct {
        bit          op;
        logic [12:0] nbytes;
        logic [13:0] rel_addr;
    } heap_req_t;

    typedef struct {
        logic [13:0] addr;
        t_status     st;
    } heap_rsp_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // [0] operation, [13:1] request_bytes, [27:14] release_address
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // [13:0] granted_address, [16:14] status

    first_fit_block_allocator dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // ------------------------------------------------------------------
    // Heap model: headers per arena byte address, free list head per page
    // ------------------------------------------------------------------
    int unsigned blk_size [ARENA];
    int unsigned blk_next [ARENA];
    bit          blk_linked [ARENA];
    bit          blk_written [ARENA];
    int unsigned written_hdrs [$];   // arena addresses of headers ever written
    int unsigned list_head [PG_COUNT];
    bit          list_valid [PG_COUNT];
    bit          pg_started [PG_COUNT];

    heap_req_t   pending_reqs [$];
    heap_rsp_t   expected_rsps [$];
    int unsigned live_blocks [$];    // payload addresses currently granted
    int          n_errors;
    int          idle_cycles;
    int          n_results;
    int          hold_left;
    bit          long_hold_done;
    int          burst_left;
    int          gap_left;

    function automatic void mark_written(int unsigned a);
        if (!blk_written[a]) begin
            blk_written[a] = 1'b1;
            written_hdrs.push_back(a);
        end
    endfunction

    // successor of prev, or the page head when there is no prev
    function automatic void relink(int unsigned pg, bit has_prev, int unsigned prev,
                                   bit valid, int unsigned target);
        if (has_prev) begin
            blk_linked[pg * PG_BYTES + prev] = valid;
            blk_next[pg * PG_BYTES + prev]   = target;
        end else begin
            list_valid[pg] = valid;
            list_head[pg]  = target;
        end
    endfunction

    function automatic t_status predict_alloc(int unsigned req, output int unsigned addr);
        bit          has_prev;
        bit          valid;
        int unsigned prev;
        int unsigned cur;
        int unsigned steps;
        int unsigned base;
        int unsigned noff;
        int          rem;
        addr = 0;
        if ((req % GRAN) != 0 || req > PG_BYTES - HDR)
            return ST_BAD_SIZE;
        for (int unsigned pg = 0; pg < PG_COUNT; pg++) begin
            base = pg * PG_BYTES;
            // first visit turns the page into one free block
            if (!pg_started[pg]) begin
                pg_started[pg]   = 1'b1;
                blk_size[base]   = PG_BYTES - HDR;
                blk_linked[base] = 1'b0;
                blk_next[base]   = 0;
                mark_written(base);
                list_valid[pg]   = 1'b1;
                list_head[pg]    = 0;
            end
            has_prev = 1'b0;
            prev     = 0;
            steps    = 0;
            valid    = list_valid[pg];
            cur      = list_head[pg];
            while (valid && steps < WALK_LIMIT) begin
                steps++;
                if (blk_size[base + cur] >= req) begin
                    // signed leftover: a tight fit goes out whole
                    rem = int'(blk_size[base + cur]) - int'(req + HDR);
                    if (rem >= HDR) begin
                        noff = cur + HDR + req;
                        blk_size[base + noff]   = rem;
                        blk_next[base + noff]   = blk_next[base + cur];
                        blk_linked[base + noff] = blk_linked[base + cur];
                        mark_written(base + noff);
                        relink(pg, has_prev, prev, 1'b1, noff);
                        blk_size[base + cur] = req;
                    end else begin
                        relink(pg, has_prev, prev, blk_linked[base + cur], blk_next[base + cur]);
                    end
                    blk_linked[base + cur] = 1'b0;
                    addr = base + cur + HDR;
                    return ST_GRANTED;
                end
                has_prev = 1'b1;
                prev     = cur;
                valid    = blk_linked[base + cur];
                cur      = blk_next[base + cur];
            end
        end
        return ST_NO_SPACE;
    endfunction

    function automatic t_status predict_free(int unsigned addr);
        int unsigned pg;
        int unsigned base;
        int unsigned off;
        int unsigned c;
        int unsigned csize;
        int unsigned prev;
        int unsigned ptr;
        int unsigned steps;
        bit          has_prev;
        bit          valid;
        if (addr >= ARENA)
            return ST_IGNORED;
        pg = addr / PG_BYTES;
        if (!pg_started[pg])
            return ST_IGNORED;
        base = pg * PG_BYTES;
        off  = addr - base;
        if (off < HDR)
            return ST_IGNORED;
        c     = off - HDR;
        csize = blk_size[base + c];
        if (csize > PG_BYTES || c + HDR + csize > PG_BYTES)
            return ST_IGNORED;
        has_prev = 1'b0;
        prev     = 0;
        steps    = 0;
        valid    = list_valid[pg];
        ptr      = list_head[pg];
        while (valid && ptr < c && steps < WALK_LIMIT) begin
            steps++;
            has_prev = 1'b1;
            prev     = ptr;
            valid    = blk_linked[base + ptr];
            ptr      = blk_next[base + ptr];
        end
        // double free, or overlap with a free neighbor
        if (valid && ptr <= c)
            return ST_IGNORED;
        if (valid && c + HDR + csize > ptr)
            return ST_IGNORED;
        if (has_prev && prev + HDR + blk_size[base + prev] > c)
            return ST_IGNORED;
        if (valid && c + HDR + csize == ptr) begin
            blk_size[base + c]   = csize + HDR + blk_size[base + ptr];
            blk_next[base + c]   = blk_next[base + ptr];
            blk_linked[base + c] = blk_linked[base + ptr];
        end else begin
            blk_next[base + c]   = ptr;
            blk_linked[base + c] = valid;
        end
        if (has_prev) begin
            if (prev + HDR + blk_size[base + prev] == c) begin
                blk_size[base + prev]   = blk_size[base + prev] + HDR + blk_size[base + c];
                blk_next[base + prev]   = blk_next[base + c];
                blk_linked[base + prev] = blk_linked[base + c];
            end else begin
                blk_next[base + prev]   = c;
                blk_linked[base + prev] = 1'b1;
            end
        end else begin
            list_head[pg]  = c;
            list_valid[pg] = 1'b1;
        end
        return ST_FREED;
    endfunction

    // Queue one request; the model advances in the same order the DUT takes them.
    function automatic void queue_request(bit op, int unsigned nbytes, int unsigned rel);
        heap_req_t   r;
        heap_rsp_t   e;
        int unsigned a;
        r.op       = op;
        r.nbytes   = nbytes[12:0];
        r.rel_addr = rel[13:0];
        a = 0;
        if (op == OP_ALLOC)
            e.st = predict_alloc(r.nbytes, a);
        else
            e.st = predict_free(r.rel_addr);
        e.addr = a[13:0];
        if (e.st == ST_GRANTED)
            live_blocks.push_back(a);
        pending_reqs.push_back(r);
        expected_rsps.push_back(e);
    endfunction

    function automatic void queue_alloc(int unsigned nbytes);
        queue_request(OP_ALLOC, nbytes, $urandom_range(0, ARENA - 1));
    endfunction

    function automatic void queue_free(int unsigned addr);
        queue_request(OP_FREE, $urandom_range(0, 8191), addr);
    endfunction

    function automatic void queue_live_free();
        int unsigned k;
        k = $urandom_range(0, live_blocks.size() - 1);
        queue_free(live_blocks[k]);
        live_blocks.delete(k);
    endfunction

    function automatic void queue_random_item();
        int unsigned roll;
        int unsigned pg;
        roll = $urandom_range(0, 99);
        if (roll < 50 || live_blocks.size() == 0) begin
            roll = $urandom_range(0, 99);
            if (roll < 80)
                queue_alloc($urandom_range(0, 32) * GRAN);
            else if (roll < 92)
                queue_alloc($urandom_range(0, (PG_BYTES - HDR) / GRAN) * GRAN);
            else
                queue_alloc($urandom_range(0, 8191));     // mostly bad sizes
        end else if (roll < 88) begin
            queue_live_free();
        end else begin
            // noise: stale or merged headers, low offsets, unstarted pages
            roll = $urandom_range(0, 2);
            pg   = $urandom_range(0, PG_COUNT - 1);
            if (roll == 0)
                queue_free(written_hdrs[$urandom_range(0, written_hdrs.size() - 1)] + HDR);
            else if (roll == 1 || !pg_started[pg])
                queue_free(pg * PG_BYTES + $urandom_range(0, HDR - 1));
            else
                queue_free(written_hdrs[$urandom_range(0, written_hdrs.size() - 1)] + HDR);
        end
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch: result %0d %s got %0d expected %0d", n_results, what, got, want);
        n_errors++;
    endtask

    // ------------------------------------------------------------------
    // Request driver: bursts with random gaps
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        heap_req_t r;
        if (!i_rst_n) begin
            s_tvalid   <= 1'b0;
            s_tdata    <= '0;
            burst_left <= 0;
            gap_left   <= 0;
        end else if (!s_tvalid || s_tready) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                r = pending_reqs.pop_front();
                s_tdata  <= {4'd0, r.rel_addr, r.nbytes, r.op};
                s_tvalid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor, receiver stall pattern and watchdog
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        heap_rsp_t e;
        if (!i_rst_n) begin
            m_tready       <= 1'b0;
            hold_left      <= 0;
            long_hold_done <= 1'b0;
            idle_cycles    <= 0;
            n_results      <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_rsps.size() == 0) begin
                    report_mismatch("unexpected result, status", m_tdata[16:14], -1);
                end else begin
                    e = expected_rsps.pop_front();
                    if (m_tdata[16:14] !== e.st)
                        report_mismatch("status", m_tdata[16:14], e.st);
                    if (m_tdata[13:0] !== e.addr)
                        report_mismatch("address", m_tdata[13:0], e.addr);
                    if (m_tdata[23:17] !== 7'd0)
                        report_mismatch("pad bits", m_tdata[23:17], 0);
                end
                n_results <= n_results + 1;
            end

            if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
                $display("tb: failure");
                $finish;
            end

            // one long hold-off so the input side backs up, then a random pattern
            if (!long_hold_done && n_results == 300) begin
                long_hold_done <= 1'b1;
                hold_left      <= 400;
                m_tready       <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_tready  <= 1'b0;
            end else if ((n_results / 100) % 3 == 0) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(0, 3) != 0);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        i_rst_n  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        m_tready = 1'b0;
        n_errors = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part
        queue_alloc(0);                       // header-only block, split off page 0
        queue_alloc(7);                       // not a granule multiple
        queue_alloc(PG_BYTES);                // larger than page room
        queue_alloc(8191);                    // all request bits set
        queue_alloc(PG_BYTES - HDR);          // no fit in page 0, starts page 1
        queue_alloc(PG_BYTES - 2 * HDR);      // tight fit, handed out whole
        queue_alloc(GRAN);                    // skips empty pages 0 and 1, starts page 2
        queue_free(3 * PG_BYTES + HDR);       // page never started
        queue_free(PG_BYTES + 4);             // header would sit below page start
        queue_free(2 * HDR);                  // free the tight-fit block
        queue_free(2 * HDR);                  // double free
        queue_free(HDR);                      // merges with the following free block
        queue_free(PG_BYTES + HDR);           // whole page 1 back
        queue_alloc(PG_BYTES - HDR);
        queue_alloc(PG_BYTES - HDR);
        queue_alloc(PG_BYTES - HDR);          // starts page 3
        queue_alloc(PG_BYTES - HDR);          // no space anywhere
        queue_free(ARENA - 1);                // top of arena, all address bits set
        while (live_blocks.size() > 0)
            queue_live_free();

        // random part, with one pause until the block has drained
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == N_RANDOM / 2) begin
                while (expected_rsps.size() > 0)
                    @(posedge i_clk);
            end
            queue_random_item();
        end

        while (pending_reqs.size() > 0 || expected_rsps.size() > 0)
            @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (n_errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
